@@ sv/lpht_pkg.sv @@
`timescale 1ns / 1ps
// Package for the linear-probing hash table: payload types, codes and shared constants.
// Used by every module of the block; it depends on nothing else.
package lpht_pkg;

   localparam int KEY_W        = 16;
   localparam int RECORD_W     = 16;
   localparam int SLOT_FIELD_W = 6;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_HOME    = 3'd0,
      STATUS_PROBED  = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_FOUND   = 3'd3,
      STATUS_MISSING = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_SCAN,
      ST_EVICT,
      ST_LOOK,
      ST_FINISH
   } lpht_state_type;

   typedef struct packed {
      op_type              op;
      logic [KEY_W-1:0]    key;
   } lpht_req_type;

   typedef struct packed {
      status_type              status;
      logic [RECORD_W-1:0]     record_index;
      logic [SLOT_FIELD_W-1:0] slot;
   } lpht_rsp_type;

   // One stored slot. at_home marks an occupant that sits in its own home slot.
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [RECORD_W-1:0] record;
      logic                at_home;
   } lpht_entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } lpht_mem_cmd_type;

endpackage

@@ sv/linear_probe_hash_table.sv @@
`timescale 1ns / 1ps
// Top level of the open-addressing hash table with linear probing.
// Depends on lpht_pkg, lpht_home and lpht_store.
//
// Usage: a request transfer on req_* carries an op (insert or look up) and a 16-bit key.
// Each request produces exactly one response transfer on rsp_* with a status, the record
// index assigned or found, and the slot used. An insert takes the next value of a
// saturating record counter; a lookup returns the first used slot whose key matches,
// scanning every slot in probe order from the key's home slot (key mod SLOTS).
// The block works on one request at a time. The home slot comes from a remainder unit
// that multiplies by a reciprocal of SLOTS. An insert into a free home slot is then
// written and loaded into the response register; the block returns to idle and can
// take the next request as that response becomes valid. An insert that probes checks
// the following slots one by one (up to SLOTS-1) and, when it evicts a misplaced
// occupant, writes the new key home in a further step. A lookup reads one slot per
// cycle, pipelined, until a key matches or the last slot has been read.
// The response sits in an output register: while the receiver holds rsp_stall high the
// response stays put, and the block already accepts and works on the next request; only
// the finished result of that one waits for the register to free up.
// csr_wr_en writes replace_mode from csr_wr_data; write it only while the block is idle.
// A synchronous reset clears the valid bits of all slots, the record counter and
// replace_mode at once; the block accepts requests in the cycle after reset.
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lpht_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lpht_rsp_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   localparam int SW = $clog2(SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   lpht_state_type      state_ff, state_in;

   // Request registers and probe bookkeeping.
   op_type              op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [SW-1:0]       home_ff;
   logic [SW-1:0]       scan_ff;
   logic [SW-1:0]       cnt_ff;
   logic                iss_done_ff;

   // Lookup read pipeline: describes the slot whose data arrives in this cycle.
   logic                pipe_valid_ff;
   logic [SW-1:0]       pipe_slot_ff;
   logic                pipe_used_ff;
   logic                pipe_last_ff;

   logic                replace_ff;
   logic [RECORD_W-1:0] rec_ctr_ff;

   status_type          res_status_ff, res_status_in;
   logic [RECORD_W-1:0] res_rec_ff, res_rec_in;
   logic [SW-1:0]       res_slot_ff, res_slot_in;
   logic                res_set;

   logic                rsp_valid_ff;
   lpht_rsp_type        rsp_ff;

   logic                hash_done;
   logic [SW-1:0]       hash_home;
   logic [SLOTS-1:0]    used_vec;
   lpht_entry_type      rd_entry;
   lpht_mem_cmd_type    mem_cmd;
   logic [SW-1:0]       mem_rd_addr;
   logic [SW-1:0]       mem_wr_addr;
   lpht_entry_type      mem_wr_data;
   logic                take_rec;

   logic                req_accept;
   logic                out_free;
   logic                key_hit;
   logic                misplaced;
   logic                slot_free;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   lpht_home #(.SLOTS(SLOTS)) u_home (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .key   (req_data.key),
      .done  (hash_done),
      .home  (hash_home)
   );

   // Accesses never overlap on one entry: an insert reads the home slot once and writes
   // only after that read has returned, and a lookup writes nothing.
   lpht_store #(.SLOTS(SLOTS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_data (rd_entry),
      .used    (used_vec)
   );

   assign req_accept = (state_ff == ST_IDLE) && req_valid;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign key_hit    = pipe_valid_ff && pipe_used_ff && (rd_entry.key == key_ff);
   // The home occupant was read when the probe started and the read data holds since.
   assign misplaced  = replace_ff && !rd_entry.at_home;
   assign slot_free  = !used_vec[scan_ff];

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_HASH;
         end
         ST_HASH: begin
            if (hash_done) begin
               if (op_ff == OP_LOOKUP) state_in = ST_LOOK;
               else if (!used_vec[hash_home]) state_in = ST_FINISH;
               else state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (slot_free) state_in = misplaced ? ST_EVICT : ST_FINISH;
            else if (cnt_ff == LAST_SLOT) state_in = ST_FINISH;
         end
         ST_EVICT: begin
            state_in = ST_FINISH;
         end
         ST_LOOK: begin
            if (key_hit || (pipe_valid_ff && pipe_last_ff)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs: memory commands, record allocation and the result to report.
   always_comb begin
      mem_cmd       = '0;
      mem_rd_addr   = hash_home;
      mem_wr_addr   = hash_home;
      mem_wr_data   = '{key: key_ff, record: rec_ctr_ff, at_home: 1'b1};
      take_rec      = 1'b0;
      res_set       = 1'b0;
      res_status_in = STATUS_HOME;
      res_rec_in    = rec_ctr_ff;
      res_slot_in   = hash_home;
      case (state_ff)
         ST_HASH: begin
            if (hash_done && op_ff == OP_INSERT) begin
               if (!used_vec[hash_home]) begin
                  mem_cmd.wr_en = 1'b1;
                  take_rec      = 1'b1;
                  res_set       = 1'b1;
               end else begin
                  mem_cmd.rd_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            mem_wr_addr = scan_ff;
            if (slot_free) begin
               mem_cmd.wr_en = 1'b1;
               take_rec      = 1'b1;
               res_set       = 1'b1;
               if (misplaced) begin
                  // The occupant moves to the free slot; the new key follows at home.
                  mem_wr_data   = '{key: rd_entry.key, record: rd_entry.record, at_home: 1'b0};
                  res_status_in = STATUS_HOME;
                  res_slot_in   = home_ff;
               end else begin
                  mem_wr_data   = '{key: key_ff, record: rec_ctr_ff, at_home: 1'b0};
                  res_status_in = STATUS_PROBED;
                  res_slot_in   = scan_ff;
               end
            end else if (cnt_ff == LAST_SLOT) begin
               res_set       = 1'b1;
               res_status_in = STATUS_FULL;
               res_rec_in    = '0;
               res_slot_in   = '0;
            end
         end
         ST_EVICT: begin
            mem_cmd.wr_en = 1'b1;
            mem_wr_addr   = home_ff;
            mem_wr_data   = '{key: key_ff, record: res_rec_ff, at_home: 1'b1};
         end
         ST_LOOK: begin
            mem_cmd.rd_en = !iss_done_ff;
            mem_rd_addr   = scan_ff;
            if (key_hit) begin
               res_set       = 1'b1;
               res_status_in = STATUS_FOUND;
               res_rec_in    = rd_entry.record;
               res_slot_in   = pipe_slot_ff;
            end else if (pipe_valid_ff && pipe_last_ff) begin
               res_set       = 1'b1;
               res_status_in = STATUS_MISSING;
               res_rec_in    = '0;
               res_slot_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         replace_ff    <= 1'b0;
         rec_ctr_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         pipe_valid_ff <= 1'b0;
         iss_done_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) replace_ff <= csr_wr_data;
         if (take_rec && rec_ctr_ff != '1) rec_ctr_ff <= rec_ctr_ff + 1'b1;
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_HASH) begin
            pipe_valid_ff <= 1'b0;
            iss_done_ff   <= 1'b0;
         end else if (state_ff == ST_LOOK) begin
            pipe_valid_ff <= !iss_done_ff;
            if (!iss_done_ff && cnt_ff == LAST_SLOT) iss_done_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_data.op;
         key_ff <= req_data.key;
      end
      if (state_ff == ST_HASH && hash_done) begin
         home_ff <= hash_home;
         if (op_ff == OP_LOOKUP) begin
            scan_ff <= hash_home;
            cnt_ff  <= '0;
         end else begin
            scan_ff <= next_slot(hash_home);
            cnt_ff  <= SW'(1);
         end
      end else if (state_ff == ST_SCAN) begin
         scan_ff <= next_slot(scan_ff);
         cnt_ff  <= cnt_ff + 1'b1;
      end else if (state_ff == ST_LOOK && !iss_done_ff) begin
         pipe_slot_ff <= scan_ff;
         pipe_used_ff <= used_vec[scan_ff];
         pipe_last_ff <= (cnt_ff == LAST_SLOT);
         scan_ff      <= next_slot(scan_ff);
         cnt_ff       <= cnt_ff + 1'b1;
      end
      if (res_set) begin
         res_status_ff <= res_status_in;
         res_rec_ff    <= res_rec_in;
         res_slot_ff   <= res_slot_in;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_ff <= '{status: res_status_ff, record_index: res_rec_ff,
                     slot: SLOT_FIELD_W'(res_slot_ff)};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An occupied slot is overwritten only by the new key that displaced a misplaced one.
   a_overwrite_only_on_evict: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en && used_vec[mem_wr_addr] |-> state_ff == ST_EVICT)
      else $error("write to an occupied slot outside eviction");

   // Once saturated, the record counter stays at its top value.
   a_counter_saturates: assert property (@(posedge clock) disable iff (reset)
      rec_ctr_ff == '1 |=> rec_ctr_ff == '1)
      else $error("record counter left saturation");

   // The home slot arrives only while a request waits for it.
   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == ST_HASH)
      else $error("remainder unit finished outside the hash state");

   // A dropped insert reports zero index and slot.
   a_full_reports_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_FULL |->
         rsp_ff.record_index == '0 && rsp_ff.slot == '0)
      else $error("dropped insert reports a nonzero index or slot");

endmodule

@@ sv/lpht_home.sv @@
`timescale 1ns / 1ps
// Remainder unit: computes key mod SLOTS by reciprocal multiplication.
// Depends on lpht_pkg.
module lpht_home import lpht_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [KEY_W-1:0]            key,
   output logic                        done,
   output logic [$clog2(SLOTS)-1:0]    home
);

   localparam int SW       = $clog2(SLOTS);
   localparam int RECIP_SH = 22;
   // With floor(2^22 / SLOTS) the estimated quotient of a 16-bit key is exact or one short.
   localparam int RECIP    = (1 << RECIP_SH) / SLOTS;
   localparam int PROD_W   = KEY_W + RECIP_SH;

   logic                  quot_valid_ff;
   logic                  done_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      quot_ff;
   logic [KEY_W-1:0]      quot_in;
   logic [SW-1:0]         rem_ff;
   logic [SW-1:0]         rem_in;
   logic [PROD_W-1:0]     prod;
   logic [KEY_W-1:0]      back;
   logic [KEY_W-1:0]      diff;
   logic [KEY_W-1:0]      diff_sub;

   // The first stage estimates the quotient; the second forms the remainder, which is
   // below twice SLOTS, so one compare and subtract corrects it.
   always_comb begin
      prod     = PROD_W'(key) * PROD_W'(RECIP);
      quot_in  = prod[PROD_W-1:RECIP_SH];
      back     = quot_ff * KEY_W'(SLOTS);
      diff     = key_ff - back;
      diff_sub = diff - KEY_W'(SLOTS);
      rem_in   = (diff >= KEY_W'(SLOTS)) ? diff_sub[SW-1:0] : diff[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         quot_valid_ff <= start;
         done_ff       <= quot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         key_ff  <= key;
         quot_ff <= quot_in;
      end
      if (quot_valid_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

@@ sv/lpht_store.sv @@
`timescale 1ns / 1ps
// Slot storage: a one-read, one-write memory of entries plus the per-slot valid bits.
// Depends on lpht_pkg.
module lpht_store import lpht_pkg::*; #(
   parameter int SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpht_mem_cmd_type            cmd,
   input  logic [$clog2(SLOTS)-1:0]    rd_addr,
   input  logic [$clog2(SLOTS)-1:0]    wr_addr,
   input  lpht_entry_type              wr_data,
   output lpht_entry_type              rd_data,
   output logic [SLOTS-1:0]            used
);

   lpht_entry_type   entry_mem_ff [SLOTS];
   lpht_entry_type   rd_data_ff;
   logic [SLOTS-1:0] used_ff;

   // Valid bits clear at reset; the entries themselves are meaningful only once written.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.wr_en) begin
         used_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign used    = used_ff;

endmodule
